FILE: sv/jtu_pkg.sv
`timescale 1ns / 1ps

package jtu_pkg;

  // fixed-point format
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int NUM_CSTAGE    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int ROT_W         = 18;
  localparam int ROT_FRAC      = 16;
  localparam int ANG_FRAC      = 30;
  localparam int AX_SHIFT      = ANG_FRAC - FRAC_BITS;

  // angle range reduction: one conditional subtract of 2*pi*2^k per cell
  localparam int RED_STEPS = 30 - FRAC_BITS;
  localparam int RED_IDX_W = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int U_W       = 63 - FRAC_BITS;

  // datapath widths
  localparam int CW   = 34;
  localparam int K2_W = 22;
  localparam int PA_W = 22;
  localparam int RJ_W = 37;

  localparam logic signed [35:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q  = CW'(64'sd652032874);
  localparam logic signed [CW:0] ONE_Q30   = (CW+1)'(64'sd1073741824);

  localparam logic [U_W-1:0] TWO_PI_U   = U_W'(64'd6746518852);
  localparam logic [U_W-1:0] RED_OFFSET = TWO_PI_U << (RED_STEPS - 1);

  typedef enum logic [1:0] {
    JT_REVOLUTE  = 2'd0,
    JT_PRISMATIC = 2'd1,
    JT_FIXED     = 2'd2
  } joint_type_t;

  typedef enum logic [2:0] {
    CFG_JOINT_TYPE = 3'd0,
    CFG_AXIS       = 3'd1,
    CFG_ROW0       = 3'd2,
    CFG_ROW1       = 3'd3,
    CFG_ROW2       = 3'd4,
    CFG_OFF_X      = 3'd5,
    CFG_OFF_Y      = 3'd6,
    CFG_OFF_Z      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]           jtype;
    logic [53:0]          axis;
    logic [2:0][53:0]     rows;
    logic [2:0][31:0]     off;
  } cfg_t;

  typedef struct packed {
    logic [U_W-1:0]     u;
    logic signed [31:0] q;
  } red_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
    logic signed [31:0]   q;
  } cordic_t;

  // arctangent of 2^-i in Q30, truncated up to i = 26 and rounded above
  function automatic logic [29:0] atan_q(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/jtu_reduce_cell.sv
`timescale 1ns / 1ps

module jtu_reduce_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vin,
  input  jtu_pkg::red_t                 din,
  input  logic [jtu_pkg::RED_IDX_W-1:0] step,
  output logic                          vout,
  output jtu_pkg::red_t                 dout
);

  logic [jtu_pkg::U_W-1:0] sub;
  jtu_pkg::red_t           dnext;

  // conditional subtract of 2*pi scaled by this cell's weight
  always_comb begin
    sub   = jtu_pkg::TWO_PI_U << step;
    dnext = din;
    if (din.u >= sub) begin
      dnext.u = din.u - sub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dnext;
    end
  end

endmodule

FILE: sv/jtu_cordic_cell.sv
`timescale 1ns / 1ps

module jtu_cordic_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  jtu_pkg::cordic_t din,
  input  logic [4:0]       idx,
  output logic             vout,
  output jtu_pkg::cordic_t dout
);

  logic signed [jtu_pkg::CW-1:0] dx;
  logic signed [jtu_pkg::CW-1:0] dy;
  logic signed [jtu_pkg::CW-1:0] at;
  jtu_pkg::cordic_t              dnext;

  // one rotation-mode micro-rotation
  always_comb begin
    dx    = din.y >>> idx;
    dy    = din.x >>> idx;
    at    = jtu_pkg::CW'(jtu_pkg::atan_q(idx));
    dnext = din;
    if (!din.z[jtu_pkg::CW-1]) begin
      dnext.x = din.x - dx;
      dnext.y = din.y + dy;
      dnext.z = din.z - at;
    end else begin
      dnext.x = din.x + dx;
      dnext.y = din.y - dy;
      dnext.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dnext;
    end
  end

endmodule

FILE: sv/jtu_compose.sv
`timescale 1ns / 1ps

module jtu_compose (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vin,
  input  logic signed [jtu_pkg::CW-1:0]    s,
  input  logic signed [jtu_pkg::CW-1:0]    c,
  input  logic signed [31:0]               q,
  input  jtu_pkg::cfg_t                    cfg,
  input  logic signed [jtu_pkg::K2_W-1:0]  k2 [3][3],
  input  logic signed [jtu_pkg::PA_W-1:0]  pa [3],
  output logic                             vout,
  output logic signed [17:0]               rot [3][3],
  output logic signed [31:0]               pos [3]
);

  logic signed [18:0]               kk   [3][3];
  logic signed [17:0]               p    [3][3];
  logic signed [31:0]               off  [3];
  logic signed [jtu_pkg::CW:0]      omc;
  logic signed [52:0]               sk   [3][3];
  logic signed [56:0]               ok   [3][3];
  logic signed [jtu_pkg::RJ_W-1:0]  rj_next [3][3];
  logic signed [jtu_pkg::RJ_W-1:0]  rj   [3][3];
  logic signed [31:0]               q1;
  logic                             v1;
  logic signed [54:0]               prod [3][3][3];
  logic signed [53:0]               pp   [3];
  logic                             v2;
  logic signed [56:0]               acc  [3][3];
  logic signed [56:0]               rr   [3][3];
  logic signed [53:0]               pt   [3];
  logic signed [39:0]               ps   [3];
  logic signed [17:0]               rot_next [3][3];
  logic signed [31:0]               pos_next [3];

  // unpack configuration and build skew matrix of the axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = signed'(cfg.off[i]);
      for (int j = 0; j < 3; j++) begin
        p[i][j] = signed'(cfg.rows[i][18*j +: 18]);
      end
    end
    kk[0][0] = 19'sd0;
    kk[1][1] = 19'sd0;
    kk[2][2] = 19'sd0;
    kk[0][1] = -19'(signed'(cfg.axis[36 +: 18]));
    kk[0][2] =  19'(signed'(cfg.axis[18 +: 18]));
    kk[1][0] =  19'(signed'(cfg.axis[36 +: 18]));
    kk[1][2] = -19'(signed'(cfg.axis[0 +: 18]));
    kk[2][0] = -19'(signed'(cfg.axis[18 +: 18]));
    kk[2][1] =  19'(signed'(cfg.axis[0 +: 18]));
  end

  // rodrigues matrix in Q30
  always_comb begin
    omc = jtu_pkg::ONE_Q30 - (jtu_pkg::CW+1)'(c);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sk[i][j] = 53'(s) * 53'(kk[i][j]);
        ok[i][j] = 57'(omc) * 57'(k2[i][j]);
        rj_next[i][j] = jtu_pkg::RJ_W'((sk[i][j] + 53'sd32768) >>> 16)
                      + jtu_pkg::RJ_W'((ok[i][j] + 57'sd32768) >>> 16);
        if (i == j) begin
          rj_next[i][j] = rj_next[i][j] + jtu_pkg::RJ_W'(jtu_pkg::ONE_Q30);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rj <= rj_next;
      q1 <= q;
    end
  end

  // partial products of parent rotation times rodrigues, and axis step
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= 54'(pa[i]) * 54'(q1);
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            prod[i][j][k] <= 55'(p[i][k]) * 55'(rj[k][j]);
          end
        end
      end
    end
  end

  // sum, round, saturate and select by joint type
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = (pp[i] + 54'sd32768) >>> 16;
      ps[i] = 40'(off[i]) + 40'(pt[i]);
      case (cfg.jtype)
        jtu_pkg::JT_PRISMATIC: begin
          if (ps[i] > 40'sd2147483647) begin
            pos_next[i] = 32'sh7FFFFFFF;
          end else if (ps[i] < -40'sd2147483648) begin
            pos_next[i] = 32'sh80000000;
          end else begin
            pos_next[i] = 32'(ps[i]);
          end
        end
        default: pos_next[i] = off[i];
      endcase
      for (int j = 0; j < 3; j++) begin
        acc[i][j] = 57'(prod[i][j][0]) + 57'(prod[i][j][1]) + 57'(prod[i][j][2]);
        rr[i][j]  = (acc[i][j] + 57'sd536870912) >>> 30;
        case (cfg.jtype)
          jtu_pkg::JT_REVOLUTE: begin
            if (rr[i][j] > 57'sd131071) begin
              rot_next[i][j] = 18'sd131071;
            end else if (rr[i][j] < -57'sd131072) begin
              rot_next[i][j] = -18'sd131072;
            end else begin
              rot_next[i][j] = 18'(rr[i][j]);
            end
          end
          default: rot_next[i][j] = p[i][j];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot <= rot_next;
      pos <= pos_next;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      vout <= v2;
    end
  end

endmodule

FILE: sv/joint_transform_update_unit.sv
`timescale 1ns / 1ps

// Joint transform unit: each joint_value transaction yields one transform
// transaction (rotation in Q1.16, position in Q16.16). The datapath is a
// pipeline that takes one transaction per cycle unless the output is held.
// It has 14 range-reduction cells, 18 CORDIC cells, then the Rodrigues
// matrix, the product with the parent rotation and the output register.
// A held output stalls the whole pipeline. Configuration is registered on
// write (the derived axis terms are registered once more) and must only
// change while no transaction is in flight.
module joint_transform_update_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [53:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] joint_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] rot_00,
  output logic signed [17:0] rot_01,
  output logic signed [17:0] rot_02,
  output logic signed [17:0] rot_10,
  output logic signed [17:0] rot_11,
  output logic signed [17:0] rot_12,
  output logic signed [17:0] rot_20,
  output logic signed [17:0] rot_21,
  output logic signed [17:0] rot_22,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z
);

  localparam int RS = jtu_pkg::RED_STEPS;
  localparam int NC = jtu_pkg::NUM_CSTAGE;

  jtu_pkg::cfg_t                    cfg;
  logic signed [jtu_pkg::K2_W-1:0]  k2 [3][3];
  logic signed [jtu_pkg::PA_W-1:0]  pa [3];
  logic signed [17:0]               ax [3];
  logic signed [17:0]               pr [3][3];
  logic signed [37:0]               n2;
  logic signed [37:0]               t2;
  logic signed [37:0]               ta;
  logic                             en;
  logic signed [jtu_pkg::U_W-1:0]   a_ext;
  jtu_pkg::red_t                    red_d [RS+1];
  logic                             red_v [RS+1];
  logic signed [35:0]               zr;
  logic signed [35:0]               zw;
  logic signed [35:0]               zf;
  jtu_pkg::cordic_t                 cor_d [NC+1];
  logic                             cor_v [NC+1];
  logic signed [jtu_pkg::CW-1:0]    s_val;
  logic signed [jtu_pkg::CW-1:0]    c_val;
  logic signed [17:0]               rot [3][3];
  logic signed [31:0]               pos [3];
  logic signed [jtu_pkg::K2_W-1:0]  k2_next [3][3];
  logic signed [jtu_pkg::PA_W-1:0]  pa_next [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jtype   <= 2'(jtu_pkg::JT_FIXED);
      cfg.axis    <= 54'd0;
      cfg.rows[0] <= 54'd65536;
      cfg.rows[1] <= 54'd17179869184;
      cfg.rows[2] <= 54'd4503599627370496;
      cfg.off     <= '0;
    end else if (cfg_we) begin
      case (jtu_pkg::cfg_idx_t'(cfg_idx))
        jtu_pkg::CFG_JOINT_TYPE: cfg.jtype   <= cfg_wdata[1:0];
        jtu_pkg::CFG_AXIS:       cfg.axis    <= cfg_wdata;
        jtu_pkg::CFG_ROW0:       cfg.rows[0] <= cfg_wdata;
        jtu_pkg::CFG_ROW1:       cfg.rows[1] <= cfg_wdata;
        jtu_pkg::CFG_ROW2:       cfg.rows[2] <= cfg_wdata;
        jtu_pkg::CFG_OFF_X:      cfg.off[0]  <= cfg_wdata[31:0];
        jtu_pkg::CFG_OFF_Y:      cfg.off[1]  <= cfg_wdata[31:0];
        jtu_pkg::CFG_OFF_Z:      cfg.off[2]  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // axis-only terms: K*K rounded to Q16 and parent rotation times axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = signed'(cfg.axis[18*i +: 18]);
      for (int j = 0; j < 3; j++) begin
        pr[i][j] = signed'(cfg.rows[i][18*j +: 18]);
      end
    end
    n2 = 38'(ax[0]) * 38'(ax[0]) + 38'(ax[1]) * 38'(ax[1]) + 38'(ax[2]) * 38'(ax[2]);
    for (int i = 0; i < 3; i++) begin
      ta = 38'(pr[i][0]) * 38'(ax[0]) + 38'(pr[i][1]) * 38'(ax[1])
         + 38'(pr[i][2]) * 38'(ax[2]);
      pa_next[i] = jtu_pkg::PA_W'((ta + 38'sd32768) >>> 16);
      for (int j = 0; j < 3; j++) begin
        t2 = 38'(ax[i]) * 38'(ax[j]);
        if (i == j) begin
          t2 = t2 - n2;
        end
        k2_next[i][j] = jtu_pkg::K2_W'((t2 + 38'sd32768) >>> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    k2 <= k2_next;
    pa <= pa_next;
  end

  // pipeline advance
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // angle to Q30, biased positive for the reduction cells
  always_comb begin
    a_ext      = jtu_pkg::U_W'(joint_value);
    red_d[0].u = jtu_pkg::U_W'(a_ext <<< jtu_pkg::AX_SHIFT) + jtu_pkg::RED_OFFSET;
    red_d[0].q = joint_value;
    red_v[0]   = in_valid;
  end

  for (genvar k = 0; k < RS; k++) begin : g_red
    jtu_reduce_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (red_v[k]),
      .din  (red_d[k]),
      .step (jtu_pkg::RED_IDX_W'(RS - 1 - k)),
      .vout (red_v[k+1]),
      .dout (red_d[k+1])
    );
  end

  // wrap into (-pi, pi] and fold into [-pi/2, pi/2]
  always_comb begin
    zr = {1'b0, red_d[RS].u[34:0]};
    zw = (zr > jtu_pkg::PI_Q) ? zr - jtu_pkg::TWO_PI_Q : zr;
    cor_d[0].neg = 1'b0;
    zf = zw;
    if (zw > jtu_pkg::HALF_PI_Q) begin
      zf = zw - jtu_pkg::PI_Q;
      cor_d[0].neg = 1'b1;
    end else if (zw < -jtu_pkg::HALF_PI_Q) begin
      zf = zw + jtu_pkg::PI_Q;
      cor_d[0].neg = 1'b1;
    end
    cor_d[0].x = jtu_pkg::GAIN_Q;
    cor_d[0].y = '0;
    cor_d[0].z = jtu_pkg::CW'(zf);
    cor_d[0].q = red_d[RS].q;
    cor_v[0]   = red_v[RS];
  end

  for (genvar k = 0; k < NC; k++) begin : g_cor
    jtu_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (cor_v[k]),
      .din  (cor_d[k]),
      .idx  (5'(k)),
      .vout (cor_v[k+1]),
      .dout (cor_d[k+1])
    );
  end

  // undo the half-turn fold
  assign s_val = cor_d[NC].neg ? -cor_d[NC].y : cor_d[NC].y;
  assign c_val = cor_d[NC].neg ? -cor_d[NC].x : cor_d[NC].x;

  jtu_compose u_compose (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (cor_v[NC]),
    .s    (s_val),
    .c    (c_val),
    .q    (cor_d[NC].q),
    .cfg  (cfg),
    .k2   (k2),
    .pa   (pa),
    .vout (out_valid),
    .rot  (rot),
    .pos  (pos)
  );

  assign rot_00 = rot[0][0];
  assign rot_01 = rot[0][1];
  assign rot_02 = rot[0][2];
  assign rot_10 = rot[1][0];
  assign rot_11 = rot[1][1];
  assign rot_12 = rot[1][2];
  assign rot_20 = rot[2][0];
  assign rot_21 = rot[2][1];
  assign rot_22 = rot[2][2];
  assign pos_x  = pos[0];
  assign pos_y  = pos[1];
  assign pos_z  = pos[2];

`ifndef SYNTHESIS
  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // fixed joint passes the parent rotation through
  a_fixed_rot: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.jtype == 2'(jtu_pkg::JT_FIXED) |-> rot_00 == pr[0][0] && rot_22 == pr[2][2])
    else $error("fixed joint rotation differs from parent");

  // only a prismatic joint moves the position away from the offset
  a_pos_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.jtype != 2'(jtu_pkg::JT_PRISMATIC) |-> pos_x == signed'(cfg.off[0]))
    else $error("position differs from offset for non-prismatic joint");
`endif

endmodule
